[hw/rtl/affc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affc_pkg
// Shared constants, codes and types for the affine cipher character unit.
// ----------------------------------------------------------------------------
package affc_pkg;

  localparam int MaxAlphabet = 64;                  // alphabet table depth
  localparam int AddrW       = $clog2(MaxAlphabet); // table address width
  localparam int SizeW       = 7;                   // alphabet_size width
  localparam int KeyW        = 6;                   // key / index width
  localparam int SymW        = 8;                   // character width
  localparam int StatW       = 2;                   // status width
  localparam int NumRegs     = 4;
  localparam int CfgAddrW    = $clog2(NumRegs * 4);
  localparam int CfgDataW    = 32;
  localparam int MulSteps    = KeyW;                // one multiplier bit per step
  localparam int StepW       = $clog2(MulSteps);

  typedef enum logic [1:0] {
    RegSize    = 2'd0,
    RegMulKey  = 2'd1,
    RegAddKey  = 2'd2,
    RegDecrypt = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpCipher = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StNoChar = 2'd1,
    StBadKey = 2'd2
  } status_e;

  // key check outcome: valid flag and inverse of the multiplicative key
  typedef struct packed {
    logic            ok;
    logic [KeyW-1:0] inv;
  } key_res_t;

endpackage

[hw/rtl/affc_keyinv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affc_keyinv
// Key check and modular inverse search, one candidate per cycle.
// ----------------------------------------------------------------------------
module affc_keyinv import affc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KeyW-1:0]  mult_key_i,
  input  logic [KeyW-1:0]  shift_key_i,
  input  logic [SizeW-1:0] modulus_i,
  output logic             done_o,
  output key_res_t         res_o
);

  logic             busy_q;
  logic             done_q;
  logic [KeyW-1:0]  v_q;
  logic [SizeW-1:0] r_q;
  key_res_t         res_q;

  logic             range_ok;
  logic             hit;
  logic             last;
  logic [SizeW-1:0] r_sum;
  logic [SizeW-1:0] r_d;

  assign range_ok = (modulus_i >= SizeW'(2)) && (modulus_i <= SizeW'(MaxAlphabet)) &&
                    ({1'b0, mult_key_i} < modulus_i) && ({1'b0, shift_key_i} < modulus_i);
  assign hit      = (r_q == SizeW'(1));
  assign last     = ({1'b0, v_q} == (modulus_i - SizeW'(1)));
  // r tracks v*a mod m
  assign r_sum    = r_q + {1'b0, mult_key_i};
  assign r_d      = (r_sum >= modulus_i) ? (r_sum - modulus_i) : r_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        v_q    <= KeyW'(1);
        r_q    <= {1'b0, mult_key_i};
      end else if (busy_q) begin
        if (!range_ok || hit || last) begin
          busy_q    <= 1'b0;
          done_q    <= 1'b1;
          res_q.ok  <= range_ok && hit;
          res_q.inv <= v_q;
        end else begin
          v_q <= v_q + KeyW'(1);
          r_q <= r_d;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/affc_modmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affc_modmul
// Bit-serial modular multiplier, multiplier MSB first (double and add).
// ----------------------------------------------------------------------------
module affc_modmul import affc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SizeW-1:0] mcand_i,   // below modulus
  input  logic [KeyW-1:0]  mplier_i,
  input  logic [SizeW-1:0] modulus_i,
  output logic             done_o,
  output logic [SizeW-1:0] prod_o
);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [SizeW-1:0] acc_q;
  logic [SizeW-1:0] mcand_q;
  logic [KeyW-1:0]  mplier_q;

  logic [SizeW-1:0] dbl;
  logic [SizeW-1:0] dbl_red;
  logic [SizeW-1:0] sum;
  logic [SizeW-1:0] sum_red;

  // acc < m <= 64, so 2*acc and acc+x both fit in SizeW bits
  assign dbl     = {acc_q[SizeW-2:0], 1'b0};
  assign dbl_red = (dbl >= modulus_i) ? (dbl - modulus_i) : dbl;
  assign sum     = dbl_red + (mplier_q[KeyW-1] ? mcand_q : '0);
  assign sum_red = (sum >= modulus_i) ? (sum - modulus_i) : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        cnt_q    <= StepW'(MulSteps - 1);
        acc_q    <= '0;
        mcand_q  <= mcand_i;
        mplier_q <= mplier_i;
      end else if (busy_q) begin
        acc_q    <= sum_red;
        mplier_q <= {mplier_q[KeyW-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - StepW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hw/rtl/affine_cipher_character_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_cipher_character_unit
// Affine substitution over a loadable alphabet of byte characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one beat is either a load
//   (operation 0: write symbol_in_i to alphabet entry entry_index_i) or a
//   cipher beat (operation 1: transform symbol_in_i).
//   Output channel (out_valid_o / out_ready_i): exactly one result beat per
//   input beat, in order. Loads return symbol 0, status ok.
//   APB port: alphabet_size, mult_key, shift_key, decrypt_mode at 0x0..0xC.
//   Write registers only while the unit is idle. pready is tied high.
// Sequencing:
//   One item in flight. A cipher beat scans the table from entry 0: the
//   table has one read port and is scanned one entry per cycle, then a
//   6-step bit-serial modular multiply runs, then one table read fetches
//   the output. A miss scans every entry below m and reports no character.
//   The first cipher beat after any register write also runs the key check
//   and inverse search, whose result is then cached.
// Reset: registers return to 26 / 1 / 0 / 0, the cached key is marked stale.
//   Alphabet entries are undefined until loaded.
// Stall: a finished result parks in the output register; the next beat is
//   accepted meanwhile, its result waits until the register drains.
// ----------------------------------------------------------------------------
module affine_cipher_character_unit import affc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [KeyW-1:0]     entry_index_i,
  input  logic [SymW-1:0]     symbol_in_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SymW-1:0]     symbol_out_o,
  output logic [StatW-1:0]    status_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    StIdle,
    StKey,
    StScan,
    StPrep,
    StMul,
    StFetch,
    StResult
  } state_e;

  // ---------------------------------------------------------------- config
  logic [SizeW-1:0] alphabet_size_q;
  logic [KeyW-1:0]  mult_key_q;
  logic [KeyW-1:0]  shift_key_q;
  logic             decrypt_q;
  logic             cfg_we;
  cfg_reg_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alphabet_size_q <= SizeW'(26);
      mult_key_q      <= KeyW'(1);
      shift_key_q     <= '0;
      decrypt_q       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_sel)
        RegSize:    alphabet_size_q <= pwdata[SizeW-1:0];
        RegMulKey:  mult_key_q      <= pwdata[KeyW-1:0];
        RegAddKey:  shift_key_q     <= pwdata[KeyW-1:0];
        RegDecrypt: decrypt_q       <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegSize:    prdata = CfgDataW'(alphabet_size_q);
      RegMulKey:  prdata = CfgDataW'(mult_key_q);
      RegAddKey:  prdata = CfgDataW'(shift_key_q);
      RegDecrypt: prdata = CfgDataW'(decrypt_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  state_e           state_q;
  logic [SymW-1:0]  sym_q;
  logic [KeyW-1:0]  pos_q;
  logic [SizeW-1:0] scan_idx_q;     // next entry to read, up to m
  logic [AddrW-1:0] cmp_idx_q;      // entry held in rd_data_q
  logic             cmp_valid_q;
  logic             key_fresh_q;    // cached key result matches registers
  logic             key_ok_q;
  logic [KeyW-1:0]  inv_q;
  logic [SymW-1:0]  res_sym_q;
  status_e          res_status_q;
  logic             out_valid_q;
  logic [SymW-1:0]  out_sym_q;
  status_e          out_status_q;

  logic             in_fire;
  logic             is_cipher;
  logic             key_start;
  logic             key_done;
  key_res_t         key_res;
  logic             mul_start;
  logic             mul_done;
  logic [SizeW-1:0] mul_prod;
  logic [SizeW-1:0] mcand;
  logic [KeyW-1:0]  mplier;
  logic [SizeW-1:0] diff_sum;
  logic [SizeW-1:0] diff_red;
  logic [SizeW-1:0] enc_sum;
  logic [SizeW-1:0] fetch_pos;
  logic             match;
  logic             out_free;

  // table
  logic [SymW-1:0]  mem [MaxAlphabet];
  logic [SymW-1:0]  rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_cipher  = (op_e'(operation_i) == OpCipher);
  assign key_start  = in_fire && is_cipher && !key_fresh_q;
  assign mem_we     = in_fire && !is_cipher;
  assign match      = cmp_valid_q && (rd_data_q == sym_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // decrypt pre-step: (pos - b) mod m
  assign diff_sum = {1'b0, pos_q} + alphabet_size_q - {1'b0, shift_key_q};
  assign diff_red = (diff_sum >= alphabet_size_q) ? (diff_sum - alphabet_size_q) : diff_sum;
  assign mcand    = decrypt_q ? {1'b0, inv_q} : {1'b0, mult_key_q};
  assign mplier   = decrypt_q ? diff_red[KeyW-1:0] : pos_q;
  assign mul_start = (state_q == StPrep);

  // encrypt post-step: + b mod m
  assign enc_sum   = mul_prod + {1'b0, shift_key_q};
  assign fetch_pos = decrypt_q ? mul_prod :
                     ((enc_sum >= alphabet_size_q) ? (enc_sum - alphabet_size_q) : enc_sum);

  assign rd_addr = ((state_q == StMul) && mul_done) ? fetch_pos[AddrW-1:0]
                                                     : scan_idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_index_i] <= symbol_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  affc_keyinv u_keyinv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (key_start),
    .mult_key_i  (mult_key_q),
    .shift_key_i (shift_key_q),
    .modulus_i   (alphabet_size_q),
    .done_o      (key_done),
    .res_o       (key_res)
  );

  affc_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mcand),
    .mplier_i  (mplier),
    .modulus_i (alphabet_size_q),
    .done_o    (mul_done),
    .prod_o    (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      sym_q        <= '0;
      pos_q        <= '0;
      scan_idx_q   <= '0;
      cmp_idx_q    <= '0;
      cmp_valid_q  <= 1'b0;
      key_fresh_q  <= 1'b0;
      key_ok_q     <= 1'b0;
      inv_q        <= '0;
      res_sym_q    <= '0;
      res_status_q <= StOk;
      out_valid_q  <= 1'b0;
      out_sym_q    <= '0;
      out_status_q <= StOk;
    end else begin
      // in StResult the output register is reloaded below instead
      if (out_valid_q && out_ready_i && (state_q != StResult)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        key_fresh_q <= 1'b0;
      end else if ((state_q == StKey) && key_done) begin
        key_fresh_q <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            sym_q        <= symbol_in_i;
            res_sym_q    <= '0;
            res_status_q <= StOk;
            scan_idx_q   <= '0;
            cmp_valid_q  <= 1'b0;
            if (!is_cipher) begin
              state_q <= StResult;
            end else if (!key_fresh_q) begin
              state_q <= StKey;
            end else if (!key_ok_q) begin
              res_status_q <= StBadKey;
              state_q      <= StResult;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StKey: begin
          if (key_done) begin
            key_ok_q    <= key_res.ok;
            inv_q       <= key_res.inv;
            if (key_res.ok) begin
              state_q <= StScan;
            end else begin
              res_status_q <= StBadKey;
              state_q      <= StResult;
            end
          end
        end
        StScan: begin
          if (match) begin
            pos_q   <= KeyW'(cmp_idx_q);
            state_q <= StPrep;
          end else if (scan_idx_q < alphabet_size_q) begin
            cmp_valid_q <= 1'b1;
            cmp_idx_q   <= scan_idx_q[AddrW-1:0];
            scan_idx_q  <= scan_idx_q + SizeW'(1);
          end else if (!cmp_valid_q) begin
            res_status_q <= StNoChar;
            state_q      <= StResult;
          end else begin
            cmp_valid_q <= 1'b0;
          end
        end
        StPrep: begin
          state_q <= StMul;
        end
        StMul: begin
          if (mul_done) begin
            state_q <= StFetch;
          end
        end
        StFetch: begin
          res_sym_q <= rd_data_q;
          state_q   <= StResult;
        end
        StResult: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_sym_q    <= res_sym_q;
            out_status_q <= res_status_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = out_sym_q;
  assign status_o     = out_status_q;

`ifndef NO_ASSERTIONS
  // cached inverse is a nonzero residue below the modulus
  a_inv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_fresh_q && key_ok_q) |->
      ((inv_q != '0) && ({1'b0, inv_q} < alphabet_size_q)))
    else $error("cached key inverse out of range");

  // the scan never compares an entry at or above the modulus
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && cmp_valid_q) |-> ({1'b0, cmp_idx_q} < alphabet_size_q))
    else $error("scan beyond alphabet size");

  // error results carry a zero character
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (symbol_out_o == '0))
    else $error("error result with nonzero character");

  // multiplier finishes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == StMul))
    else $error("unexpected multiplier completion");
`endif

endmodule
